FILE: rtl/i2cm_pkg.sv
// I2C master bit engine: shared types and constants.
// Used by the interfaces' users, the front, the queue and the back end.
`default_nettype none

package i2cm_pkg;

  // Command codes as they arrive on the input channel
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_WACK  = 3'd5,
    OP_ACK   = 3'd6,
    OP_NACK  = 3'd7
  } op_t;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd10;
  localparam logic [3:0] BYTE_BITS       = 4'd8;
  localparam logic [3:0] LAST_BIT        = 4'd7;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Decoded word handed from the front to the back end
  typedef struct packed {
    op_t        op;
    logic       load_shift;
    logic [7:0] shift_init;
    logic       sda_in;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/i2cm_if.sv
// I2C master bit engine: valid/ready channel interfaces for the command input,
// the per-tick result output and the phase length configuration write.
`default_nettype none

interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, output cmd, output tx_byte, output sda_in, input ready);
  modport sink   (input valid, input cmd, input tx_byte, input sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_missing;

  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output rx_byte, output ack_missing, input ready);
  modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input rx_byte, input ack_missing, output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/i2cm_front.sv
// I2C master bit engine front: accepts command words and decodes them
// into queue entries. Depends on i2cm_pkg and i2cm_in_if.
`default_nettype none

module i2cm_front
  import i2cm_pkg::*;
(
  i2cm_in_if.sink in_bus,
  output logic    push_valid,
  input  logic    push_ready,
  output item_t   push_item
);

  op_t op;

  always_comb begin
    op                   = op_t'(in_bus.cmd);
    push_item.op         = op;
    // write loads the byte, read clears the shifter, others leave it alone
    push_item.load_shift = (op == OP_WRITE) || (op == OP_READ);
    push_item.shift_init = (op == OP_WRITE) ? in_bus.tx_byte : 8'd0;
    push_item.sda_in     = in_bus.sda_in;
  end

  assign push_valid   = in_bus.valid;
  assign in_bus.ready = push_ready;

endmodule

`default_nettype wire

FILE: rtl/i2cm_fifo.sv
// I2C master bit engine: short queue of decoded words between front and back.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_fifo
  import i2cm_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t          mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/i2cm_back.sv
// I2C master bit engine back end: phase sequencer for SCL/SDA, delay counter,
// byte shifter and the result register. Depends on i2cm_pkg and the interfaces.
`default_nettype none

module i2cm_back
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  i2cm_cfg_if.sink    cfg_bus,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  item_t       pop_item,
  i2cm_out_if.source  out_bus
);

  logic [7:0] phase_ticks_r;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  op_t        op_r, op_nxt;
  logic [2:0] step_r, step_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shreg_r, shreg_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [7:0] rxv_r, rxv_nxt;
  logic       ack_r, ack_nxt;
  logic       done_r, done_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic       pop;
  logic       run;
  logic       more;
  logic [2:0] p;
  logic [7:0] dlen;

  // state registers double as the result word; they only move on a pop
  assign pop_ready = !out_valid_r || out_bus.ready;
  assign pop       = pop_valid && pop_ready;
  assign dlen      = (phase_ticks_r == 8'd0) ? 8'd1 : phase_ticks_r;

  assign cfg_bus.ready = 1'b1;

  always_comb begin
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    op_nxt    = op_r;
    step_nxt  = step_r;
    bit_nxt   = bit_r;
    shreg_nxt = shreg_r;
    tick_nxt  = tick_r;
    rxv_nxt   = rxv_r;
    ack_nxt   = ack_r;
    done_nxt  = 1'b0;
    run       = 1'b0;
    more      = 1'b0;
    p         = 3'd0;

    if (op_r == OP_NONE) begin
      if (pop_item.op != OP_NONE) begin
        op_nxt   = pop_item.op;
        step_nxt = 3'd0;
        bit_nxt  = 4'd0;
        if (pop_item.load_shift) begin
          shreg_nxt = pop_item.shift_init;
        end
        run = 1'b1;
      end
    end else begin
      tick_nxt = tick_r - 8'd1;
      if (tick_nxt == 8'd0) begin
        step_nxt = step_r + 3'd1;
        p        = step_nxt;
        run      = 1'b1;
      end
    end

    if (run) begin
      unique case (op_nxt)
        OP_START: begin
          if (p == 3'd0) begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
            more    = 1'b1;
          end else if (p == 3'd1) begin
            sda_nxt = 1'b0;
            more    = 1'b1;
          end else if (p == 3'd2) begin
            scl_nxt = 1'b0;
            more    = 1'b1;
          end
        end
        OP_STOP: begin
          if (p == 3'd0) begin
            sda_nxt = 1'b0;
            scl_nxt = 1'b1;
            more    = 1'b1;
          end else begin
            sda_nxt = 1'b1;
          end
        end
        OP_WRITE: begin
          if (p == 3'd3) begin
            bit_nxt = bit_r + 4'd1;
          end
          if (!(p == 3'd3 && bit_nxt >= BYTE_BITS)) begin
            if (p == 3'd3) begin
              // next bit: wrap back to the data setup phase
              step_nxt = 3'd0;
              p        = 3'd0;
            end
            more = 1'b1;
            if (p == 3'd0) begin
              sda_nxt = shreg_nxt[7];
            end else if (p == 3'd1) begin
              scl_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b0;
              if (bit_nxt == LAST_BIT) begin
                sda_nxt = 1'b1;
              end
              shreg_nxt = {shreg_nxt[6:0], 1'b0};
            end
          end
        end
        OP_READ: begin
          if (p == 3'd2) begin
            bit_nxt = bit_r + 4'd1;
          end
          if (p == 3'd2 && bit_nxt >= BYTE_BITS) begin
            rxv_nxt = shreg_nxt;
          end else begin
            if (p == 3'd2) begin
              step_nxt = 3'd0;
              p        = 3'd0;
            end
            more = 1'b1;
            if (p == 3'd0) begin
              scl_nxt = 1'b1;
            end else begin
              shreg_nxt = {shreg_nxt[6:0], pop_item.sda_in};
              scl_nxt   = 1'b0;
            end
          end
        end
        OP_WACK: begin
          if (p == 3'd0) begin
            sda_nxt = 1'b1;
            more    = 1'b1;
          end else if (p == 3'd1) begin
            scl_nxt = 1'b1;
            more    = 1'b1;
          end else if (p == 3'd2) begin
            ack_nxt = pop_item.sda_in;
            scl_nxt = 1'b0;
            more    = 1'b1;
          end
        end
        OP_ACK: begin
          if (p == 3'd0) begin
            sda_nxt = 1'b0;
            more    = 1'b1;
          end else if (p == 3'd1) begin
            scl_nxt = 1'b1;
            more    = 1'b1;
          end else if (p == 3'd2) begin
            scl_nxt = 1'b0;
            more    = 1'b1;
          end else begin
            sda_nxt = 1'b1;
          end
        end
        OP_NACK: begin
          if (p == 3'd0) begin
            sda_nxt = 1'b1;
            more    = 1'b1;
          end else if (p == 3'd1) begin
            scl_nxt = 1'b1;
            more    = 1'b1;
          end else if (p == 3'd2) begin
            scl_nxt = 1'b0;
            more    = 1'b1;
          end
        end
        default: more = 1'b0;
      endcase

      if (more) begin
        tick_nxt = dlen;
      end else begin
        op_nxt   = OP_NONE;
        step_nxt = 3'd0;
        done_nxt = 1'b1;
      end
    end

    priority if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_bus.valid) begin
      phase_ticks_r <= cfg_bus.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      op_r        <= OP_NONE;
      step_r      <= 3'd0;
      bit_r       <= 4'd0;
      shreg_r     <= 8'd0;
      tick_r      <= 8'd0;
      rxv_r       <= 8'd0;
      ack_r       <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        op_r    <= op_nxt;
        step_r  <= step_nxt;
        bit_r   <= bit_nxt;
        shreg_r <= shreg_nxt;
        tick_r  <= tick_nxt;
        rxv_r   <= rxv_nxt;
        ack_r   <= ack_nxt;
        done_r  <= done_nxt;
      end
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.scl_out     = scl_r;
  assign out_bus.sda_out     = sda_r;
  assign out_bus.busy_res    = (op_r != OP_NONE);
  assign out_bus.done_res    = done_r;
  assign out_bus.rx_byte     = rxv_r;
  assign out_bus.ack_missing = ack_r;

  a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (op_r == OP_NONE) |-> (step_r == 3'd0))
    else $error("phase step left nonzero while idle");

  a_busy_has_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (op_r != OP_NONE) |-> (tick_r != 8'd0))
    else $error("sequence running with an expired delay counter");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (op_r == OP_NONE))
    else $error("done reported while still busy");

  a_idle_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && op_r == OP_NONE && pop_item.op == OP_NONE) |=> (op_r == OP_NONE && !done_r))
    else $error("idle word started or finished a sequence");

endmodule

`default_nettype wire

FILE: rtl/i2c_master_bit_engine_top.sv
// I2C master bit engine top level. One result word per command word.
// Path: an accepted input word is written into the queue register, then popped into the
// sequencer register, which drives the result word.
// Throughput: one word per cycle; a stalled result holds the sequencer and the 2-entry queue.
// Reset (rst_n, synchronous): lines released, engine idle, queue empty,
// phase length 10 ticks. Depends on i2cm_pkg, i2cm_if and the submodules.
`default_nettype none

module i2c_master_bit_engine_top
  import i2cm_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  i2cm_in_if.sink     in_bus,
  i2cm_out_if.source  out_bus,
  i2cm_cfg_if.sink    cfg_bus
);

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  i2cm_front u_front (
    .in_bus     (in_bus),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  i2cm_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  i2cm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_bus   (cfg_bus),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_bus   (out_bus)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_i2c_master_bit_engine_top.sv
// Self-checking testbench for i2c_master_bit_engine_top: drives command ticks,
// predicts the SCL/SDA drive and status word for every tick, compares each result.
// Depends on i2cm_pkg, the i2cm_*_if interfaces and the top level RTL.
`timescale 1ns / 100ps

module tb_i2c_master_bit_engine_top;
  import i2cm_pkg::*;

  // Engine state as the predictor keeps it
  typedef struct {
    bit [7:0] plen;
    bit       scl;
    bit       sda;
    op_t      op;
    bit [2:0] ph;
    bit [3:0] bit_no;
    bit [7:0] shreg;
    bit [7:0] wait_cnt;
    bit [7:0] rdval;
    bit       nack;
  } bus_state_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       nack;
  } line_word_t;

  typedef struct packed {
    op_t      cmd;
    bit [7:0] tx;
    bit       sda;
  } tick_t;

  logic clk = 1'b0;
  logic rst_n;

  i2cm_in_if  in_bus();
  i2cm_out_if out_bus();
  i2cm_cfg_if cfg_bus();

  i2c_master_bit_engine_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always #10 clk = ~clk;

  bus_state_t gen;          // stimulus-side copy, used to time well-formed sequences
  bus_state_t chk;          // checking copy, advanced on accepted words
  tick_t      pending_ticks[$];
  line_word_t expected_lines[$];
  tick_t      nxt;
  line_word_t got_word;
  line_word_t want_word;
  int         n_pushed;
  int         n_taken;
  int         n_results;
  int         n_errors;
  int         send_gap;
  int         recv_wait;
  logic       in_calm;
  logic       out_calm;
  logic       hold_off;

  function automatic bus_state_t idle_engine();
    bus_state_t s;
    s.plen     = PHASE_TICKS_RST;
    s.scl      = 1'b1;
    s.sda      = 1'b1;
    s.op       = OP_NONE;
    s.ph       = '0;
    s.bit_no   = '0;
    s.shreg    = '0;
    s.wait_cnt = '0;
    s.rdval    = '0;
    s.nack     = 1'b0;
    return s;
  endfunction

  // Line changes of the current phase; 1 when a delay follows
  function automatic bit bus_phase(inout bus_state_t s, input bit sda_i);
    bit [2:0] p;
    p = s.ph;
    case (s.op)
      OP_START: begin
        if (p == 3'd0) begin s.sda = 1'b1; s.scl = 1'b1; return 1'b1; end
        if (p == 3'd1) begin s.sda = 1'b0; return 1'b1; end
        if (p == 3'd2) begin s.scl = 1'b0; return 1'b1; end
        return 1'b0;
      end
      OP_STOP: begin
        if (p == 3'd0) begin s.sda = 1'b0; s.scl = 1'b1; return 1'b1; end
        s.sda = 1'b1;
        return 1'b0;
      end
      OP_WRITE: begin
        if (p == 3'd3) begin
          s.bit_no = s.bit_no + 4'd1;
          if (s.bit_no >= BYTE_BITS) return 1'b0;
          s.ph = '0;
          p = '0;
        end
        if (p == 3'd0) begin s.sda = s.shreg[7]; return 1'b1; end
        if (p == 3'd1) begin s.scl = 1'b1; return 1'b1; end
        s.scl = 1'b0;
        if (s.bit_no == LAST_BIT) s.sda = 1'b1;  // release SDA for the ACK slot
        s.shreg = s.shreg << 1;
        return 1'b1;
      end
      OP_READ: begin
        if (p == 3'd2) begin
          s.bit_no = s.bit_no + 4'd1;
          if (s.bit_no >= BYTE_BITS) begin s.rdval = s.shreg; return 1'b0; end
          s.ph = '0;
          p = '0;
        end
        if (p == 3'd0) begin s.scl = 1'b1; return 1'b1; end
        s.shreg = {s.shreg[6:0], sda_i};
        s.scl = 1'b0;
        return 1'b1;
      end
      OP_WACK: begin
        if (p == 3'd0) begin s.sda = 1'b1; return 1'b1; end
        if (p == 3'd1) begin s.scl = 1'b1; return 1'b1; end
        if (p == 3'd2) begin s.nack = sda_i; s.scl = 1'b0; return 1'b1; end
        return 1'b0;
      end
      OP_ACK: begin
        if (p == 3'd0) begin s.sda = 1'b0; return 1'b1; end
        if (p == 3'd1) begin s.scl = 1'b1; return 1'b1; end
        if (p == 3'd2) begin s.scl = 1'b0; return 1'b1; end
        s.sda = 1'b1;
        return 1'b0;
      end
      OP_NACK: begin
        if (p == 3'd0) begin s.sda = 1'b1; return 1'b1; end
        if (p == 3'd1) begin s.scl = 1'b1; return 1'b1; end
        if (p == 3'd2) begin s.scl = 1'b0; return 1'b1; end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // One tick of the engine: advances the state, returns the result word
  function automatic line_word_t bus_tick(inout bus_state_t s, input op_t c,
                                          input bit [7:0] tx, input bit sda_i);
    line_word_t r;
    bit fin;
    fin = 1'b0;
    if (s.op == OP_NONE) begin
      if (c != OP_NONE) begin
        s.op = c;
        s.ph = '0;
        s.bit_no = '0;
        if (c == OP_WRITE) s.shreg = tx;
        else if (c == OP_READ) s.shreg = '0;
        if (bus_phase(s, sda_i)) begin
          s.wait_cnt = (s.plen == 8'd0) ? 8'd1 : s.plen;
        end else begin
          s.op = OP_NONE;
          fin = 1'b1;
        end
      end
    end else begin
      s.wait_cnt = s.wait_cnt - 8'd1;
      if (s.wait_cnt == 8'd0) begin
        s.ph = s.ph + 3'd1;
        if (bus_phase(s, sda_i)) begin
          s.wait_cnt = (s.plen == 8'd0) ? 8'd1 : s.plen;
        end else begin
          s.op = OP_NONE;
          s.ph = '0;
          fin = 1'b1;
        end
      end
    end
    r.scl  = s.scl;
    r.sda  = s.sda;
    r.busy = (s.op != OP_NONE);
    r.done = fin;
    r.rx   = s.rdval;
    r.nack = s.nack;
    return r;
  endfunction

  task automatic note_error(input string what, input logic [7:0] got, input logic [7:0] want);
    n_errors++;
    if (n_errors <= 40)
      $display("mismatch on word %0d, %s: got %h want %h", n_results, what, got, want);
  endtask

  function automatic int draw_wait(input logic calm);
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_lines.push_back(bus_tick(chk, op_t'(in_bus.cmd), in_bus.tx_byte,
                                          in_bus.sda_in));
        n_taken++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          nxt = pending_ticks.pop_front();
          in_bus.valid   <= 1'b1;
          in_bus.cmd     <= nxt.cmd;
          in_bus.tx_byte <= nxt.tx;
          in_bus.sda_in  <= nxt.sda;
          send_gap = draw_wait(in_calm);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got_word = {out_bus.scl_out, out_bus.sda_out, out_bus.busy_res, out_bus.done_res,
                    out_bus.rx_byte, out_bus.ack_missing};
        if (expected_lines.size() == 0) begin
          note_error("word with nothing expected", got_word.rx, 8'h00);
        end else begin
          want_word = expected_lines.pop_front();
          if (got_word.scl !== want_word.scl)
            note_error("scl_out", 8'(got_word.scl), 8'(want_word.scl));
          if (got_word.sda !== want_word.sda)
            note_error("sda_out", 8'(got_word.sda), 8'(want_word.sda));
          if (got_word.busy !== want_word.busy)
            note_error("busy_res", 8'(got_word.busy), 8'(want_word.busy));
          if (got_word.done !== want_word.done)
            note_error("done_res", 8'(got_word.done), 8'(want_word.done));
          if (got_word.rx !== want_word.rx) note_error("rx_byte", got_word.rx, want_word.rx);
          if (got_word.nack !== want_word.nack)
            note_error("ack_missing", 8'(got_word.nack), 8'(want_word.nack));
        end
        n_results++;
        recv_wait = draw_wait(out_calm);
      end
      if (hold_off) begin
        out_bus.ready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Stretches with and without idling on either side
  initial begin
    in_calm  = 1'b1;
    out_calm = 1'b1;
    forever begin
      repeat ($urandom_range(40, 400)) @(posedge clk);
      if ($urandom_range(0, 1)) in_calm <= ~in_calm;
      else out_calm <= ~out_calm;
    end
  end

  // Long receiver hold-off while the sender keeps offering words
  initial begin
    hold_off = 1'b0;
    while (n_taken < 700) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #15_000_000;
    $display("tb_i2c_master_bit_engine_top: errors");
    $finish;
  end

  // -------------------------------------------------------------- stimulus
  task automatic push_tick(input op_t c, input bit [7:0] tx, input bit s);
    tick_t t;
    void'(bus_tick(gen, c, tx, s));
    t.cmd = c;
    t.tx  = tx;
    t.sda = s;
    pending_ticks.push_back(t);
    n_pushed++;
  endtask

  task automatic pad(input int n);
    repeat (n) push_tick(OP_NONE, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // sda_mode: 0 random, 1 held low, 2 held high.
  // noise: percent of busy ticks that carry a (to be ignored) command.
  task automatic issue(input op_t c, input bit [7:0] tx, input int sda_mode, input int noise);
    bit s;
    if ($urandom_range(0, 1)) pad($urandom_range(1, 3));
    s = (sda_mode == 0) ? 1'($urandom_range(0, 1)) : (sda_mode == 2);
    push_tick(c, tx, s);
    while (gen.op != OP_NONE) begin
      s = (sda_mode == 0) ? 1'($urandom_range(0, 1)) : (sda_mode == 2);
      if ($urandom_range(0, 99) < noise)
        push_tick(op_t'($urandom_range(1, 7)), 8'($urandom), s);
      else
        push_tick(OP_NONE, 8'($urandom), s);
    end
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || expected_lines.size() != 0 || in_bus.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Engine is idle here: every queued sequence has run to its end
  task automatic set_phase_len(input bit [7:0] v);
    drain();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    gen.plen = v;
    chk.plen = v;
  endtask

  initial begin
    int base;
    int phase_base;
    int nz;
    in_bus.valid    = 1'b0;
    in_bus.cmd      = OP_NONE;
    in_bus.tx_byte  = '0;
    in_bus.sda_in   = 1'b0;
    out_bus.ready   = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.data    = '0;
    rst_n           = 1'b0;
    n_pushed  = 0;
    n_taken   = 0;
    n_results = 0;
    n_errors  = 0;
    send_gap  = 0;
    recv_wait = 0;
    gen = idle_engine();
    chk = idle_engine();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset phase length, then every command, byte extremes, both ACK levels
    pad(3);
    issue(OP_START, 8'h00, 0, 0);
    set_phase_len(8'd2);
    issue(OP_WRITE, 8'h00, 0, 0);
    issue(OP_WACK,  8'h00, 1, 0);
    issue(OP_WRITE, 8'hFF, 0, 0);
    issue(OP_WACK,  8'h00, 2, 0);
    issue(OP_READ,  8'h00, 2, 0);
    issue(OP_ACK,   8'h00, 0, 0);
    issue(OP_READ,  8'hFF, 1, 0);
    issue(OP_NACK,  8'h00, 0, 0);
    issue(OP_STOP,  8'h00, 0, 0);
    // commands on every busy tick, the finishing tick included
    issue(OP_WRITE, 8'hA5, 0, 100);
    issue(OP_READ,  8'h3C, 0, 100);
    pad(2);

    set_phase_len(8'd1);
    issue(OP_START, 8'h00, 0, 0);
    issue(OP_STOP,  8'h00, 0, 0);
    // zero acts as one tick
    set_phase_len(8'd0);
    issue(OP_WRITE, 8'h5A, 0, 0);
    issue(OP_WACK,  8'h00, 0, 0);
    set_phase_len(8'd255);
    issue(OP_STOP,  8'h00, 0, 5);

    // Random: mostly well-formed transfers, some loose commands
    base = n_pushed;
    while (n_pushed - base < 920) begin
      if ($urandom_range(0, 9) == 0) set_phase_len(8'($urandom_range(0, 24)));
      else set_phase_len(8'($urandom_range(1, 4)));
      phase_base = n_pushed;
      while (n_pushed - phase_base < 200) begin
        nz = $urandom_range(0, 1) ? 0 : 20;
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 4))
            issue(op_t'($urandom_range(0, 7)), 8'($urandom), 0, 30);
        end else begin
          issue(OP_START, 8'($urandom), 0, nz);
          issue(OP_WRITE, 8'($urandom), 0, nz);
          issue(OP_WACK, 8'($urandom), 0, nz);
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 1)) begin
              issue(OP_WRITE, 8'($urandom), 0, nz);
              issue(OP_WACK, 8'($urandom), 0, nz);
            end else begin
              issue(OP_READ, 8'($urandom), 0, nz);
              issue($urandom_range(0, 1) ? OP_ACK : OP_NACK, 8'($urandom), 0, nz);
            end
          end
          issue(OP_STOP, 8'($urandom), 0, nz);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (n_errors == 0 && expected_lines.size() == 0) begin
      $display("tb_i2c_master_bit_engine_top: clean");
    end else begin
      $display("tb_i2c_master_bit_engine_top: errors");
    end
    $finish;
  end

endmodule
